FILE: rtl/assert_macros.svh
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication: whenever pre holds, post holds too.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever pre holds, post holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

FILE: rtl/pcpa_pkg.sv
// Shared types and constants of the per-CPU page allocator.
package pcpa_pkg;

   localparam int ADDR_W    = 56;
   localparam int BASE_W    = ADDR_W + 1;
   localparam int LIMIT_W   = 13;
   localparam int CPU_ID_W  = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [ADDR_W-1:0]  REGION_START_RST = 56'h0000_0080_0000_00;
   localparam logic [ADDR_W-1:0]  REGION_STOP_RST  = 56'h0000_0088_0000_00;
   localparam logic [LIMIT_W-1:0] STEAL_LIMIT_RST  = 13'd64;

   localparam logic ACT_FREE  = 1'b0;
   localparam logic ACT_ALLOC = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_START = 2'd0,
      CSR_REGION_STOP  = 2'd1,
      CSR_STEAL_LIMIT  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_FREE = 2'd1,
      ST_OOM      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_STEAL,
      S_POP
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  region_start;
      logic [ADDR_W-1:0]  region_stop;
      logic [BASE_W-1:0]  base;
      logic [BASE_W-1:0]  limit;
      logic [LIMIT_W-1:0] steal_limit;
   } cfg_type;

   typedef struct packed {
      logic                action;
      logic [CPU_ID_W-1:0] cpu_id;
      logic [ADDR_W-1:0]   page_address;
   } req_type;

   typedef struct packed {
      logic              got_page;
      logic [ADDR_W-1:0] alloc_address;
      status_type        status;
   } rsp_type;

endpackage

FILE: rtl/pcpa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pcpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/pcpa_csr.sv
// Configuration registers plus the derived region base and limit.
module pcpa_csr #(
   parameter int NUM_PAGES  = 32768,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pcpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pcpa_pkg::ADDR_W-1:0]    csr_wdata,
   output pcpa_pkg::cfg_type              cfg
);
   import pcpa_pkg::*;

   localparam int PB_W = $clog2(PAGE_BYTES);
   localparam logic [BASE_W-1:0] PB_MASK  = BASE_W'(PAGE_BYTES - 1);
   localparam logic [BASE_W-1:0] SPAN     = BASE_W'(NUM_PAGES) << PB_W;
   localparam logic [BASE_W-1:0] BASE_RST = {1'b0, REGION_START_RST};

   logic [ADDR_W-1:0]  start_ff, start_in;
   logic [ADDR_W-1:0]  stop_ff, stop_in;
   logic [LIMIT_W-1:0] steal_ff, steal_in;
   logic [BASE_W-1:0]  base_ff, base_in;
   logic [BASE_W-1:0]  limit_ff, limit_in;
   logic               wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      start_in = start_ff;
      stop_in  = stop_ff;
      steal_in = steal_ff;
      base_in  = base_ff;
      if (wr) begin
         case (csr_index)
            CSR_REGION_START: begin
               start_in = csr_wdata;
               // Round the start up to the next page boundary.
               base_in  = ({1'b0, csr_wdata} + PB_MASK) & ~PB_MASK;
            end
            CSR_REGION_STOP: begin
               stop_in = csr_wdata;
            end
            CSR_STEAL_LIMIT: begin
               steal_in = csr_wdata[LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The limit is updated together with the base on the same write.
   assign limit_in = base_in + SPAN;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= REGION_START_RST;
         stop_ff  <= REGION_STOP_RST;
         steal_ff <= STEAL_LIMIT_RST;
         base_ff  <= BASE_RST;
         limit_ff <= BASE_RST + SPAN;
      end else begin
         start_ff <= start_in;
         stop_ff  <= stop_in;
         steal_ff <= steal_in;
         base_ff  <= base_in;
         limit_ff <= limit_in;
      end
   end

   assign cfg = '{region_start: start_ff, region_stop: stop_ff, base: base_ff,
                  limit: limit_ff, steal_limit: steal_ff};

endmodule

FILE: rtl/pcpa_engine.sv
// Sequencer that pushes, pops and steals pages through the link memory.
`include "assert_macros.svh"

module pcpa_engine #(
   parameter int NUM_CPUS   = 8,
   parameter int NUM_PAGES  = 32768,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  pcpa_pkg::req_type              in_item,
   input  pcpa_pkg::cfg_type              cfg,
   output logic                           res_valid,
   input  logic                           res_ready,
   output pcpa_pkg::rsp_type              res,
   output logic                           mem_we,
   output logic [$clog2(NUM_PAGES)-1:0]   mem_waddr,
   output logic [$clog2(NUM_PAGES):0]     mem_wdata,
   output logic                           mem_re,
   output logic [$clog2(NUM_PAGES)-1:0]   mem_raddr,
   input  logic [$clog2(NUM_PAGES):0]     mem_rdata
);
   import pcpa_pkg::*;

   localparam int IDX_W = $clog2(NUM_PAGES);
   localparam int CPU_W = $clog2(NUM_CPUS);
   localparam int PB_W  = $clog2(PAGE_BYTES);
   localparam int IDS   = 2 ** CPU_ID_W;
   localparam logic [CPU_W:0] SCAN_END = (CPU_W + 1)'(NUM_CPUS);

   state_type state_ff, state_in;

   logic                act_ff;
   logic [CPU_W-1:0]    cpu_ff;
   logic [ADDR_W-1:0]   pa_ff;

   logic [IDX_W-1:0]    head_ff [NUM_CPUS];
   logic [NUM_CPUS-1:0] head_valid_ff;
   logic                head_wr_en;
   logic [CPU_W-1:0]    head_wr_sel;
   logic [IDX_W-1:0]    head_wr_idx;
   logic                head_wr_v;

   logic [IDX_W-1:0]    own_head_ff, own_head_in;
   logic                own_v_ff, own_v_in;
   logic [LIMIT_W-1:0]  left_ff, left_in;
   logic [CPU_W:0]      scan_ff, scan_in;

   logic [CPU_W-1:0]    cpu_lut [IDS];
   logic [CPU_W-1:0]    scan_sel;
   logic [CPU_W-1:0]    head_sel;
   logic [IDX_W-1:0]    head_rd;
   logic                head_rd_v;
   logic [IDX_W-1:0]    rd_idx;
   logic                rd_v;
   logic [IDX_W-1:0]    free_idx;
   logic                free_bad;
   logic                scan_done;
   logic                scan_skip;
   logic [BASE_W-1:0]   addr_sum;

   // CPU ids beyond the CPU count fold back onto the existing CPUs.
   for (genvar g = 0; g < IDS; g++) begin : g_cpu_lut
      assign cpu_lut[g] = CPU_W'(g % NUM_CPUS);
   end

   assign scan_sel  = scan_ff[CPU_W-1:0];
   assign head_sel  = (state_ff == S_DECODE) ? cpu_ff : scan_sel;
   assign head_rd   = head_ff[head_sel];
   assign head_rd_v = head_valid_ff[head_sel];
   assign rd_idx    = mem_rdata[IDX_W-1:0];
   assign rd_v      = mem_rdata[IDX_W];

   // Both addresses are page aligned when the free is good, so the page
   // index only needs the low bits of the difference.
   assign free_idx = pa_ff[PB_W +: IDX_W] - cfg.base[PB_W +: IDX_W];
   assign free_bad = (pa_ff[PB_W-1:0] != '0)
                  || (pa_ff < cfg.region_start)
                  || (pa_ff >= cfg.region_stop)
                  || ({1'b0, pa_ff} < cfg.base)
                  || ({1'b0, pa_ff} >= cfg.limit);

   assign scan_done = (scan_ff == SCAN_END) || (left_ff == '0);
   assign scan_skip = (scan_sel == cpu_ff) || !head_rd_v;
   assign addr_sum  = cfg.base + (BASE_W'(own_head_ff) << PB_W);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (act_ff == ACT_FREE) begin
               if (res_ready) begin
                  state_in = S_IDLE;
               end
            end else if (head_rd_v) begin
               state_in = S_POP;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               if (own_v_ff) begin
                  state_in = S_POP;
               end else if (res_ready) begin
                  state_in = S_IDLE;
               end
            end else if (!scan_skip) begin
               state_in = S_STEAL;
            end
         end
         S_STEAL: begin
            state_in = S_SCAN;
         end
         S_POP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath controls.
   always_comb begin
      in_ready    = (state_ff == S_IDLE);
      res_valid   = 1'b0;
      res         = '{got_page: 1'b0, alloc_address: '0, status: ST_OK};
      mem_we      = 1'b0;
      mem_waddr   = head_rd;
      mem_wdata   = {own_v_ff, own_head_ff};
      mem_re      = 1'b0;
      mem_raddr   = head_rd;
      head_wr_en  = 1'b0;
      head_wr_sel = cpu_ff;
      head_wr_idx = rd_idx;
      head_wr_v   = rd_v;
      own_head_in = own_head_ff;
      own_v_in    = own_v_ff;
      left_in     = left_ff;
      scan_in     = scan_ff;
      case (state_ff)
         S_DECODE: begin
            if (act_ff == ACT_FREE) begin
               res_valid  = 1'b1;
               res.status = free_bad ? ST_BAD_FREE : ST_OK;
               if (res_ready && !free_bad) begin
                  mem_we      = 1'b1;
                  mem_waddr   = free_idx;
                  mem_wdata   = {head_rd_v, head_rd};
                  head_wr_en  = 1'b1;
                  head_wr_idx = free_idx;
                  head_wr_v   = 1'b1;
               end
            end else begin
               own_head_in = head_rd;
               own_v_in    = head_rd_v;
               left_in     = cfg.steal_limit;
               scan_in     = '0;
               mem_re      = head_rd_v;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               if (own_v_ff) begin
                  mem_re    = 1'b1;
                  mem_raddr = own_head_ff;
               end else begin
                  res_valid  = 1'b1;
                  res.status = ST_OOM;
               end
            end else if (scan_skip) begin
               scan_in = scan_ff + 1'b1;
            end else begin
               mem_re = 1'b1;
            end
         end
         S_STEAL: begin
            // Pop the victim's head and push that page onto the own list.
            head_wr_en  = 1'b1;
            head_wr_sel = scan_sel;
            mem_we      = 1'b1;
            own_head_in = head_rd;
            own_v_in    = 1'b1;
            left_in     = left_ff - 1'b1;
         end
         S_POP: begin
            res_valid         = 1'b1;
            res.got_page      = 1'b1;
            res.alloc_address = addr_sum[ADDR_W-1:0];
            head_wr_en        = res_ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_valid_ff <= '0;
         own_v_ff      <= 1'b0;
         left_ff       <= '0;
         scan_ff       <= '0;
      end else begin
         state_ff <= state_in;
         own_v_ff <= own_v_in;
         left_ff  <= left_in;
         scan_ff  <= scan_in;
         if (head_wr_en) begin
            head_valid_ff[head_wr_sel] <= head_wr_v;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         act_ff <= in_item.action;
         cpu_ff <= cpu_lut[in_item.cpu_id];
         pa_ff  <= in_item.page_address;
      end
      if (head_wr_en) begin
         head_ff[head_wr_sel] <= head_wr_idx;
      end
      own_head_ff <= own_head_in;
   end

   `ASSERT_IMPL(a_no_mem_rw_overlap, clock, reset, mem_we, !mem_re)
   `ASSERT_IMPL(a_steal_within_limit, clock, reset, state_ff == S_STEAL, left_ff != '0)
   `ASSERT_IMPL(a_never_steal_own, clock, reset, state_ff == S_STEAL, scan_sel != cpu_ff)
   `ASSERT_NEXT(a_result_ends_item, clock, reset, res_valid && res_ready, state_ff == S_IDLE)

endmodule

FILE: rtl/per_cpu_page_free_list_allocator_top.sv
// Top level of the per-CPU free-list page allocator with stealing.
//
// Requests arrive as words on the req_ stream: tuser says free or allocate,
// tdata carries the CPU id and, for a free, the page address. Each request
// produces exactly one word on the rsp_ stream with the status, a got-page
// flag in tuser and the allocated address. Region start, region stop and
// steal limit go in on the csr_ port; the user must write them only while no
// request is in flight, since the block itself does not enforce it.
//
// One request is worked on at a time. An allocation from a non-empty list
// reads the successor link from the registered read port of the link memory
// in S_DECODE and returns the page in S_POP. An allocation from an empty list
// first scans the other CPUs in order, skipping empty ones; each stolen page
// has its link read in S_SCAN and rewritten in S_STEAL.
//
// Reset empties every CPU list at once through the head valid bits; the link
// memory needs no clearing since a link is always written before it is read.
// The result sits in an output register; if the receiver stalls, the block
// holds its next result until that register is free, and a new request can
// still be accepted while a result waits.
module per_cpu_page_free_list_allocator_top #(
   parameter int NUM_CPUS   = 8,
   parameter int NUM_PAGES  = 32768,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request stream.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [63:0]                    req_tdata,   // cpu_id, page_address
   input  logic                           req_tuser,   // action
   // Result stream.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [63:0]                    rsp_tdata,   // alloc_address, status
   output logic                           rsp_tuser,   // got_page
   // Configuration write port.
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pcpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pcpa_pkg::ADDR_W-1:0]    csr_wdata
);
   import pcpa_pkg::*;

   localparam int IDX_W  = $clog2(NUM_PAGES);
   localparam int LINK_W = IDX_W + 1;

   cfg_type            cfg;
   req_type            req_item;
   rsp_type            res;
   logic               res_valid;
   logic               res_ready;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [LINK_W-1:0]  mem_wdata;
   logic               mem_re;
   logic [IDX_W-1:0]   mem_raddr;
   logic [LINK_W-1:0]  mem_rdata;

   // Unpack the request word: cpu_id in the low bits, the address above it.
   assign req_item = '{action: req_tuser, cpu_id: req_tdata[CPU_ID_W-1:0],
                       page_address: req_tdata[CPU_ID_W +: ADDR_W]};

   pcpa_csr #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pcpa_engine #(
      .NUM_CPUS   (NUM_CPUS),
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // Link memory: one successor index plus its valid bit per page.
   pcpa_ram #(
      .WIDTH (LINK_W),
      .DEPTH (NUM_PAGES)
   ) u_link_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // The output register is free when empty or being drained this cycle.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.got_page;
   assign rsp_tdata  = {6'b0, rsp_ff.status, rsp_ff.alloc_address};

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the per-CPU free-list page allocator with stealing.
module testbench;
   import pcpa_pkg::*;

   // Block sizes. These match the block's defaults and are passed to the instance.
   localparam int NUM_CPUS   = 8;
   localparam int NUM_PAGES  = 32768;
   localparam int PAGE_BYTES = 4096;
   localparam int IDX_W      = $clog2(NUM_PAGES);

   // Longest run of cycles with no word moving on any channel. This leaves room
   // for the slowest correct request, a long run of steals, and for the longest
   // random stalls.
   localparam int STALL_LIMIT = 40000;

   // Number of random requests in each phase of the random traffic.
   localparam int PHASE_ITEMS = 150;

   // Default region base, used by the directed tests.
   localparam logic [ADDR_W-1:0] REGION_BASE_DEFAULT = REGION_START_RST;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // Every input of the block starts at a known value. Reset is high from time zero.
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [63:0]          req_tdata  = '0;  // cpu_id, page_address
   logic                 req_tuser  = 1'b0; // action
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [63:0]          rsp_tdata;        // alloc_address, status
   logic                 rsp_tuser;        // got_page
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = CSR_REGION_START;
   logic [ADDR_W-1:0]    csr_wdata  = '0;

   // Our own copy of the allocator: registers, list heads and the link memory.
   logic [ADDR_W-1:0]  cfg_start = REGION_START_RST;
   logic [ADDR_W-1:0]  cfg_stop  = REGION_STOP_RST;
   logic [LIMIT_W-1:0] cfg_steal = STEAL_LIMIT_RST;
   logic [IDX_W-1:0]   head_page [NUM_CPUS];
   bit                 head_ok   [NUM_CPUS];
   logic [IDX_W-1:0]   link_next [NUM_PAGES];
   bit                 link_ok   [NUM_PAGES];

   // Results predicted for accepted requests, oldest first.
   rsp_type outstanding_grants[$];
   rsp_type head_grant;

   int error_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;

   per_cpu_page_free_list_allocator_top #(
      .NUM_CPUS   (NUM_CPUS),
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // The base is the region start rounded up to a whole page. It is wider
   // than an address, since rounding up near the top of the space can carry out.
   function automatic logic [63:0] region_base();
      logic [63:0] s;
      s = {8'b0, cfg_start};
      return ((s + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
   endfunction

   function automatic void push_page(input logic [2:0] cpu, input logic [IDX_W-1:0] pg);
      link_next[pg] = head_page[cpu];
      link_ok[pg]   = head_ok[cpu];
      head_page[cpu] = pg;
      head_ok[cpu]   = 1'b1;
   endfunction

   // Only called on a list whose head is valid.
   function automatic logic [IDX_W-1:0] pop_page(input logic [2:0] cpu);
      logic [IDX_W-1:0] pg;
      pg = head_page[cpu];
      head_page[cpu] = link_next[pg];
      head_ok[cpu]   = link_ok[pg];
      return pg;
   endfunction

   // Works out the result of one request and updates the lists to match.
   function automatic rsp_type predict_grant(input logic action, input logic [2:0] cpu,
                                             input logic [ADDR_W-1:0] pa);
      rsp_type          r;
      logic [63:0]      base;
      logic [63:0]      idx;
      logic [63:0]      addr64;
      logic [IDX_W-1:0] pg;
      int               left;
      int               c;
      r.got_page      = 1'b0;
      r.alloc_address = '0;
      r.status        = ST_OK;
      base = region_base();
      if (action == ACT_FREE) begin
         idx = ({8'b0, pa} - base) / PAGE_BYTES;
         if ((pa % PAGE_BYTES) != 0 || pa < cfg_start || pa >= cfg_stop ||
             {8'b0, pa} < base || idx >= NUM_PAGES) begin
            r.status = ST_BAD_FREE;
         end else begin
            push_page(cpu, idx[IDX_W-1:0]);
         end
      end else begin
         // An empty list first takes pages from the other CPUs, lowest index first.
         if (!head_ok[cpu]) begin
            left = int'(cfg_steal);
            for (c = 0; c < NUM_CPUS && left != 0; c++) begin
               if (c != cpu) begin
                  while (head_ok[c] && left != 0) begin
                     pg = pop_page(3'(c));
                     push_page(cpu, pg);
                     left--;
                  end
               end
            end
         end
         if (head_ok[cpu]) begin
            pg = pop_page(cpu);
            addr64 = base + 64'(pg) * PAGE_BYTES;
            r.got_page      = 1'b1;
            r.alloc_address = addr64[ADDR_W-1:0];
         end else begin
            r.status = ST_OOM;
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------------

   function automatic logic [ADDR_W-1:0] random_address();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[ADDR_W-1:0];
   endfunction

   // Sends one request word and records its predicted result once accepted.
   // tvalid stays high after the accept so that a following word can go out on
   // the very next cycle; a gap, when one is drawn, lowers it for a while first.
   task automatic send_request(input logic action, input logic [2:0] cpu,
                               input logic [ADDR_W-1:0] pa);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {5'b0, pa, cpu};
      do @(posedge clock); while (!req_tready);
      outstanding_grants.push_back(predict_grant(action, cpu, pa));
   endtask

   // Stops sending and waits until every predicted result has come back.
   task automatic drain_grants();
      req_tvalid <= 1'b0;
      while (outstanding_grants.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [ADDR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_REGION_START: cfg_start = value;
         CSR_REGION_STOP:  cfg_stop  = value;
         CSR_STEAL_LIMIT:  cfg_steal = value[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // Registers are only written with the block idle, so drain first. The three
   // writes go back to back with csr_valid held high throughout.
   task automatic configure(input logic [ADDR_W-1:0] start, input logic [ADDR_W-1:0] stop,
                            input logic [LIMIT_W-1:0] steal);
      drain_grants();
      write_reg(CSR_REGION_START, start);
      write_reg(CSR_REGION_STOP, stop);
      write_reg(CSR_STEAL_LIMIT, {{(ADDR_W-LIMIT_W){1'b0}}, steal});
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 45; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 45; end
         default:       begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
   endtask

   // The receiver draws a fresh ready every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // Each result word is held against the oldest prediction, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outstanding_grants.size() == 0) begin
            report_mismatch("result word with no request waiting", rsp_tdata, '0);
         end else begin
            head_grant = outstanding_grants.pop_front();
            if (rsp_tuser !== head_grant.got_page)
               report_mismatch("got_page", 64'(rsp_tuser), 64'(head_grant.got_page));
            if (rsp_tdata[ADDR_W-1:0] !== head_grant.alloc_address)
               report_mismatch("alloc_address", 64'(rsp_tdata[ADDR_W-1:0]),
                               64'(head_grant.alloc_address));
            if (rsp_tdata[ADDR_W+1:ADDR_W] !== head_grant.status)
               report_mismatch("status", 64'(rsp_tdata[ADDR_W+1:ADDR_W]),
                               64'(head_grant.status));
         end
      end
   end

   // The watchdog ends the run if nothing moves on any channel for too long.
   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Directed tests, run with the reset region unless they change it
   // ---------------------------------------------------------------------------

   // Unaligned, below the region, at its stop, and the top of the address space.
   task automatic test_bad_free_addresses();
      send_request(ACT_FREE, 3'd0, REGION_BASE_DEFAULT + 1);
      send_request(ACT_FREE, 3'd0, '0);
      send_request(ACT_FREE, 3'd0, REGION_STOP_RST);
      send_request(ACT_FREE, 3'd0, '1);
   endtask

   // Pages come back in reverse order of freeing. The last page of the region is used.
   task automatic test_lifo_order();
      send_request(ACT_FREE, 3'd1, REGION_BASE_DEFAULT);
      send_request(ACT_FREE, 3'd1, REGION_BASE_DEFAULT + PAGE_BYTES);
      send_request(ACT_FREE, 3'd1, REGION_STOP_RST - PAGE_BYTES);
      send_request(ACT_ALLOC, 3'd1, '0);
      send_request(ACT_ALLOC, 3'd1, '1);
   endtask

   // CPU 7 has nothing and takes pages from CPU 1 and CPU 3, then runs out.
   task automatic test_steal_from_others();
      send_request(ACT_FREE, 3'd3, REGION_BASE_DEFAULT + 2 * PAGE_BYTES);
      send_request(ACT_ALLOC, 3'd7, '0);
      send_request(ACT_ALLOC, 3'd7, '0);
      send_request(ACT_ALLOC, 3'd7, '0);
   endtask

   // With a limit of zero nothing is stolen; with one, a single page moves.
   task automatic test_steal_limit();
      configure(REGION_START_RST, REGION_STOP_RST, '0);
      send_request(ACT_FREE, 3'd2, REGION_BASE_DEFAULT);
      send_request(ACT_ALLOC, 3'd5, '0);
      configure(REGION_START_RST, REGION_STOP_RST, 13'd1);
      send_request(ACT_FREE, 3'd2, REGION_BASE_DEFAULT + PAGE_BYTES);
      send_request(ACT_ALLOC, 3'd5, '0);
      send_request(ACT_ALLOC, 3'd2, '0);
   endtask

   // A page freed twice links to itself, so the list keeps handing it out.
   // This list stays in place and gets stolen from during the random traffic.
   task automatic test_double_free();
      send_request(ACT_FREE, 3'd4, REGION_BASE_DEFAULT + 3 * PAGE_BYTES);
      send_request(ACT_FREE, 3'd4, REGION_BASE_DEFAULT + 3 * PAGE_BYTES);
      send_request(ACT_ALLOC, 3'd4, '0);
      send_request(ACT_ALLOC, 3'd4, '0);
   endtask

   // An unaligned start pushes the base up one page, a page index past the link
   // memory is refused, and a base that carries past the top of the address space
   // rebuilds a listed page to an address that wraps around to zero.
   task automatic test_region_rebase();
      configure(REGION_BASE_DEFAULT + 1, REGION_BASE_DEFAULT + 56'h1000_0000, 13'd4096);
      send_request(ACT_FREE, 3'd6, REGION_BASE_DEFAULT);
      send_request(ACT_FREE, 3'd6, REGION_BASE_DEFAULT + PAGE_BYTES);
      send_request(ACT_FREE, 3'd6, REGION_BASE_DEFAULT + PAGE_BYTES + NUM_PAGES * PAGE_BYTES);
      configure('1, '1, 13'd4096);
      send_request(ACT_ALLOC, 3'd6, '0);
   endtask

   // ---------------------------------------------------------------------------
   // Random traffic
   // ---------------------------------------------------------------------------

   // Each phase sets a region and limit of its own and an idling mode, then sends
   // mostly in-region frees and allocations. Frees go mostly to the low CPUs and
   // allocations to any CPU, so the high CPUs often find their lists empty and
   // steal. The remaining requests are bad frees of several kinds.
   task automatic test_random_phase(input int phase);
      logic [ADDR_W-1:0]  start;
      logic [ADDR_W-1:0]  stop;
      logic [LIMIT_W-1:0] steal;
      logic [63:0]        base;
      logic [63:0]        addr64;
      logic [2:0]         cpu;
      int                 first_page;
      int                 span;
      int                 pick;
      int                 k;
      first_page = 0;
      case (phase % 8)
         0: begin
            start = REGION_BASE_DEFAULT;
            span  = 64;
            steal = 13'd64;
         end
         1: begin
            // Region right at the top of the address space.
            start = 56'hFF_FFFF_FFFD_0000;
            span  = 48;
            steal = 13'd1;
         end
         2: begin
            start = '0;
            span  = 32;
            steal = 13'd4096;
         end
         3: begin
            // Unaligned start somewhere in the space.
            start = (random_address() & 56'hFF_FFFF_FFF0_0000) |
                    ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
            span  = 80;
            steal = 13'($urandom_range(1, 16));
         end
         4: begin
            start = random_address() & 56'hFF_FFFF_FFF0_0000;
            span  = 40;
            steal = '1;
         end
         5: begin
            // Pages on both sides of the end of the link memory.
            start      = REGION_BASE_DEFAULT;
            first_page = NUM_PAGES - 24;
            span       = 40;
            steal      = 13'd2;
         end
         6: begin
            start = REGION_BASE_DEFAULT;
            span  = 128;
            steal = 13'($urandom_range(1, 4096));
         end
         default: begin
            start = REGION_BASE_DEFAULT;
            span  = 16;
            steal = 13'd3;
         end
      endcase
      if (phase % 8 == 1)
         stop = '1;
      else if (phase % 8 == 5)
         stop = start + (NUM_PAGES + 16) * PAGE_BYTES;
      else
         stop = start + span * PAGE_BYTES;
      configure(start, stop, steal);
      set_idling(idle_mode_type'(phase % 4));
      base = region_base();
      for (k = 0; k < PHASE_ITEMS; k++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            cpu = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
            addr64 = base + (first_page + $urandom_range(span - 1)) * PAGE_BYTES;
            send_request(ACT_FREE, cpu, addr64[ADDR_W-1:0]);
         end else if (pick < 85) begin
            send_request(ACT_ALLOC, 3'($urandom_range(7)), random_address());
         end else begin
            case ($urandom_range(3))
               0: addr64 = {8'b0, random_address()};
               1: addr64 = base + $urandom_range(span - 1) * PAGE_BYTES +
                           $urandom_range(1, PAGE_BYTES - 1);
               2: addr64 = {8'b0, stop};
               default: addr64 = base - PAGE_BYTES;
            endcase
            send_request(ACT_FREE, 3'($urandom_range(7)), addr64[ADDR_W-1:0]);
         end
      end
   endtask

   task automatic test_random_traffic();
      int phase;
      for (phase = 0; phase < 8; phase++)
         test_random_phase(phase);
   endtask

   // ---------------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------------

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      set_idling(IDLE_NONE);
      test_bad_free_addresses();
      test_lifo_order();
      test_steal_from_others();
      test_steal_limit();
      test_double_free();
      test_region_rebase();
      test_random_traffic();
      // Let every result come home, then watch a little longer for stray words.
      drain_grants();
      repeat (20) @(posedge clock);
      if (outstanding_grants.size() != 0)
         report_mismatch("results never delivered", 64'(outstanding_grants.size()), '0);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/pcpa_pkg.sv
rtl/pcpa_ram.sv
rtl/pcpa_csr.sv
rtl/pcpa_engine.sv
rtl/per_cpu_page_free_list_allocator_top.sv
tb/testbench.sv
